/* hdl/fat32_sector_parser_unit_macros.svh */
// assertion macros for the fat32 sector parser
// used by fat32_sector_parser_unit; clock clk_i and reset rst_ni must be in scope
`ifndef FAT32_SECTOR_PARSER_UNIT_MACROS_SVH
`define FAT32_SECTOR_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

// implication check, sampled on clk_i, off while in reset
`define F32SP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define F32SP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define F32SP_ASSERT(lbl, prop, msg)
`define F32SP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* hdl/f32sp_pkg.sv */
// shared types and constants of the fat32 sector parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package f32sp_pkg;

  // byte offsets inside the 512 byte sector
  localparam logic [8:0] OFS_BPS     = 9'd11;
  localparam logic [8:0] OFS_SPC     = 9'd13;
  localparam logic [8:0] OFS_RSV     = 9'd14;
  localparam logic [8:0] OFS_NFATS   = 9'd16;
  localparam logic [8:0] OFS_FATSZ   = 9'd36;
  localparam logic [8:0] OFS_ROOT    = 9'd44;
  localparam logic [8:0] OFS_TYPE    = 9'd82;
  localparam logic [8:0] TYPE_LEN    = 9'd5;
  localparam logic [8:0] MBR_TABLE   = 9'h1BE;
  localparam logic [8:0] MBR_END     = 9'h1FE;
  localparam logic [3:0] MBR_TYPE_OFS = 4'd4;
  localparam logic [3:0] MBR_LBA_OFS  = 4'd8;
  localparam logic [3:0] MBR_LBA_LAST = 4'd11;
  localparam logic [8:0] SIG_OFS_A   = 9'd510;
  localparam logic [8:0] SIG_OFS_B   = 9'd511;
  localparam logic [8:0] LAST_POS    = 9'd511;

  // expected field values
  localparam logic [7:0]  SIG_BYTE_A   = 8'h55;
  localparam logic [7:0]  SIG_BYTE_B   = 8'hAA;
  localparam logic [7:0]  PART_FAT32   = 8'h0B;
  localparam logic [7:0]  PART_FAT32_L = 8'h0C;
  localparam logic [15:0] SECTOR_BYTES = 16'd512;
  localparam logic [31:0] MIN_CLUSTER  = 32'd2;

  // result widths
  localparam int unsigned OUT_DATA_W = 160;

  // result kind carried in tuser
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BOOT = 2'd1,
    KIND_MBR  = 2'd2
  } kind_e;

  // expected type text "FAT32", one character per index
  function automatic logic [7:0] type_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h33;
      3'd4:    c = 8'h32;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/fat32_sector_parser_unit.sv */
// Bytes of a 512 byte sector enter one per cycle on the slave stream while ready is high, with
// tuser marking the first byte of a sector; each byte only updates captured fields and flags.
// After byte 511 one result leaves on the master stream through three registers: the check
// register, a stage that registers the fat count times fat size product and the fat start, and
// the output register that adds the product to form the data start. Input ready drops only
// while a finished result is held up by the master side and the check of the next result has
// nowhere to go. Write sector_base_lba only while the block is idle.
// top level of the fat32 boot sector and mbr parser
// depends on f32sp_pkg and fat32_sector_parser_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "fat32_sector_parser_unit_macros.svh"

module fat32_sector_parser_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration: sector_base_lba
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_data_i,
  // byte stream in
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] sector_start
  // result stream out
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] part_start_lba, [63:32] fat_lba, [95:64] data_start_lba, [112:96] cluster_bytes,
  // [120:113] cluster_sectors, [152:121] root_dir_cluster, [159:153] zero
  output logic [159:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser    // [1:0] sector_kind
);

  // configuration register
  logic [31:0] base_lba_q;

  // byte position and captured fields
  logic [8:0]  pos_q, pos_d, cur_pos;
  logic [15:0] bps_q, bps_d;
  logic [7:0]  spc_q, spc_d;
  logic [15:0] rsv_q, rsv_d;
  logic [7:0]  nfats_q, nfats_d;
  logic [31:0] fatsz_q, fatsz_d;
  logic [31:0] root_q, root_d;
  logic        type_ok_q, type_ok_d;
  logic        sig_ok_q, sig_ok_d;
  logic        ent_match_q, ent_match_d;
  logic        part_found_q, part_found_d;
  logic [31:0] part_lba_q, part_lba_d;

  // check and result stages
  logic        eval_q, eval_d;
  logic        s1_v_q;
  f32sp_pkg::kind_e s1_kind_q;
  logic [31:0] s1_part_q, s1_fat_q, s1_prod_q, s1_root_q;
  logic [7:0]  s1_spc_q;
  logic        out_v_q;
  logic [159:0] out_data_q;
  logic [1:0]  out_user_q;

  logic        in_xfer, last_byte, out_ready, s1_take, s1_move;
  logic [7:0]  b;
  logic [8:0]  type_off, mbr_off;
  logic [3:0]  rel;
  logic        boot_ok;
  logic [39:0] prod_full;
  logic [31:0] fat_sum, data_sum;
  logic [16:0] cl_bytes;

  // handshake and pipeline flow
  assign out_ready     = !out_v_q || m_axis_tready;
  assign s1_take       = !s1_v_q || out_ready;
  assign s1_move       = s1_v_q && out_ready;
  assign s_axis_tready = !(eval_q && !s1_take);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign cur_pos       = s_axis_tuser ? 9'd0 : pos_q;
  assign last_byte     = (cur_pos == f32sp_pkg::LAST_POS);
  assign type_off      = cur_pos - f32sp_pkg::OFS_TYPE;
  assign mbr_off       = cur_pos - f32sp_pkg::MBR_TABLE;
  assign rel           = mbr_off[3:0];

  // per byte field capture and checks
  always_comb begin
    pos_d        = pos_q;
    bps_d        = bps_q;
    spc_d        = spc_q;
    rsv_d        = rsv_q;
    nfats_d      = nfats_q;
    fatsz_d      = fatsz_q;
    root_d       = root_q;
    type_ok_d    = type_ok_q;
    sig_ok_d     = sig_ok_q;
    ent_match_d  = ent_match_q;
    part_found_d = part_found_q;
    part_lba_d   = part_lba_q;
    if (in_xfer) begin
      pos_d = cur_pos + 9'd1;
      if (cur_pos == 9'd0) begin
        type_ok_d    = 1'b1;
        sig_ok_d     = 1'b1;
        ent_match_d  = 1'b0;
        part_found_d = 1'b0;
      end
      if (cur_pos == f32sp_pkg::OFS_BPS)        bps_d[7:0]  = b;
      if (cur_pos == f32sp_pkg::OFS_BPS + 9'd1) bps_d[15:8] = b;
      if (cur_pos == f32sp_pkg::OFS_SPC)        spc_d       = b;
      if (cur_pos == f32sp_pkg::OFS_RSV)        rsv_d[7:0]  = b;
      if (cur_pos == f32sp_pkg::OFS_RSV + 9'd1) rsv_d[15:8] = b;
      if (cur_pos == f32sp_pkg::OFS_NFATS)      nfats_d     = b;
      // four byte little-endian words, lane picked by the low offset bits
      if (cur_pos >= f32sp_pkg::OFS_FATSZ && cur_pos < f32sp_pkg::OFS_FATSZ + 9'd4) begin
        fatsz_d[8*(cur_pos[1:0] - f32sp_pkg::OFS_FATSZ[1:0]) +: 8] = b;
      end
      if (cur_pos >= f32sp_pkg::OFS_ROOT && cur_pos < f32sp_pkg::OFS_ROOT + 9'd4) begin
        root_d[8*(cur_pos[1:0] - f32sp_pkg::OFS_ROOT[1:0]) +: 8] = b;
      end
      // type text compare
      if (cur_pos >= f32sp_pkg::OFS_TYPE &&
          cur_pos < f32sp_pkg::OFS_TYPE + f32sp_pkg::TYPE_LEN) begin
        if (b != f32sp_pkg::type_char(type_off[2:0])) type_ok_d = 1'b0;
      end
      // boot signature
      if (cur_pos == f32sp_pkg::SIG_OFS_A && b != f32sp_pkg::SIG_BYTE_A) sig_ok_d = 1'b0;
      if (cur_pos == f32sp_pkg::SIG_OFS_B && b != f32sp_pkg::SIG_BYTE_B) sig_ok_d = 1'b0;
      // partition table scan, first fat32 entry wins
      if (cur_pos >= f32sp_pkg::MBR_TABLE && cur_pos < f32sp_pkg::MBR_END) begin
        if (rel == f32sp_pkg::MBR_TYPE_OFS && !part_found_q &&
            (b == f32sp_pkg::PART_FAT32 || b == f32sp_pkg::PART_FAT32_L)) begin
          ent_match_d = 1'b1;
        end
        if (ent_match_q && rel >= f32sp_pkg::MBR_LBA_OFS &&
            rel <= f32sp_pkg::MBR_LBA_LAST) begin
          part_lba_d[8*rel[1:0] +: 8] = b;
          if (rel == f32sp_pkg::MBR_LBA_LAST) begin
            part_found_d = 1'b1;
            ent_match_d  = 1'b0;
          end
        end
      end
    end
  end

  // check is pending once the last byte is taken until stage one takes it
  assign eval_d = (in_xfer && last_byte) || (eval_q && !s1_take);

  // validity and geometry of the finished sector
  assign boot_ok   = sig_ok_q && (bps_q == f32sp_pkg::SECTOR_BYTES) && (spc_q != 8'd0) &&
                     (nfats_q != 8'd0) && (fatsz_q != 32'd0) &&
                     (root_q >= f32sp_pkg::MIN_CLUSTER) && type_ok_q;
  assign prod_full = nfats_q * fatsz_q;
  assign fat_sum   = base_lba_q + {16'd0, rsv_q};
  assign data_sum  = s1_fat_q + s1_prod_q;
  assign cl_bytes  = {s1_spc_q, 9'd0};

  // control registers and captured state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_lba_q   <= 32'd0;
      pos_q        <= 9'd0;
      bps_q        <= 16'd0;
      spc_q        <= 8'd0;
      rsv_q        <= 16'd0;
      nfats_q      <= 8'd0;
      fatsz_q      <= 32'd0;
      root_q       <= 32'd0;
      type_ok_q    <= 1'b1;
      sig_ok_q     <= 1'b1;
      ent_match_q  <= 1'b0;
      part_found_q <= 1'b0;
      part_lba_q   <= 32'd0;
      eval_q       <= 1'b0;
      s1_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) base_lba_q <= cfg_data_i;
      pos_q        <= pos_d;
      bps_q        <= bps_d;
      spc_q        <= spc_d;
      rsv_q        <= rsv_d;
      nfats_q      <= nfats_d;
      fatsz_q      <= fatsz_d;
      root_q       <= root_d;
      type_ok_q    <= type_ok_d;
      sig_ok_q     <= sig_ok_d;
      ent_match_q  <= ent_match_d;
      part_found_q <= part_found_d;
      part_lba_q   <= part_lba_d;
      eval_q       <= eval_d;
      if (s1_take) s1_v_q <= eval_q;
      if (out_ready) out_v_q <= s1_v_q;
    end
  end

  // stage one payload: kind, partition start, fat start, product, cluster sectors, root cluster
  always_ff @(posedge clk_i) begin
    if (eval_q && s1_take) begin
      s1_kind_q <= f32sp_pkg::KIND_NONE;
      s1_part_q <= 32'd0;
      s1_fat_q  <= 32'd0;
      s1_prod_q <= 32'd0;
      s1_spc_q  <= 8'd0;
      s1_root_q <= 32'd0;
      if (boot_ok) begin
        s1_kind_q <= f32sp_pkg::KIND_BOOT;
        s1_fat_q  <= fat_sum;
        s1_prod_q <= prod_full[31:0];
        s1_spc_q  <= spc_q;
        s1_root_q <= root_q;
      end else if (part_found_q) begin
        s1_kind_q <= f32sp_pkg::KIND_MBR;
        s1_part_q <= part_lba_q;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= {7'd0, s1_root_q, s1_spc_q, cl_bytes, data_sum, s1_fat_q, s1_part_q};
      out_user_q <= s1_kind_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  `F32SP_ASSERT_NEVER(a_kind_legal, m_axis_tvalid && m_axis_tuser != f32sp_pkg::KIND_NONE && m_axis_tuser != f32sp_pkg::KIND_BOOT && m_axis_tuser != f32sp_pkg::KIND_MBR, "illegal sector kind")
  `F32SP_ASSERT(a_geom_only_boot, (m_axis_tvalid && m_axis_tuser != f32sp_pkg::KIND_BOOT) |-> (m_axis_tdata[152:32] == 121'd0), "geometry set without boot sector")
  `F32SP_ASSERT(a_start_restarts, (in_xfer && s_axis_tuser) |=> (pos_q == 9'd1), "start mark did not restart position")
  `F32SP_ASSERT(a_result_from_s1, $rose(out_v_q) |-> $past(s1_v_q), "result without stage one entry")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for fat32_sector_parser_unit: streams 512 byte sectors, predicts the
// boot sector / partition table result of each one and compares it with the result stream
// depends on f32sp_pkg and the fat32_sector_parser_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import f32sp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD_CYCLES = 6000;
  localparam logic [39:0] FS_NAME = "FAT32";

  // ways to spoil an otherwise valid boot sector
  typedef enum int {
    FLAW_NONE, FLAW_BPS, FLAW_SPC, FLAW_NFATS, FLAW_FATSZ, FLAW_ROOT, FLAW_TEXT, FLAW_SIG
  } flaw_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } sector_byte_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] part_lba;
    logic [31:0] fat_lba;
    logic [31:0] data_start;
    logic [16:0] clus_bytes;
    logic [7:0]  clus_secs;
    logic [31:0] root_clus;
  } sector_info_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  sector_byte_t byte_q[$];
  sector_info_t sector_q[$];
  logic [7:0]   sec_buf[512];

  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  logic quiet = 1'b0;
  logic rx_hold = 1'b0;
  logic stall_req = 1'b0;

  // predictor state
  logic [31:0] base_lba = '0;
  logic [8:0]  pos_q = '0;
  logic [15:0] bps_f = '0;
  logic [7:0]  spc_f = '0;
  logic [15:0] rsv_f = '0;
  logic [7:0]  nfats_f = '0;
  logic [31:0] fatsz_f = '0;
  logic [31:0] root_f = '0;
  logic        name_ok = 1'b1;
  logic        sig_ok = 1'b1;
  logic        ent_hit = 1'b0;
  logic        part_found = 1'b0;
  logic [31:0] part_lba_f = '0;

  fat32_sector_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // track one accepted byte, queue the sector result after the last one
  task automatic parse_byte(input logic [7:0] b, input logic st);
    logic [8:0]   p;
    logic [8:0]   off;
    logic [3:0]   rel;
    logic [31:0]  fat_start;
    sector_info_t r;
    if (st) pos_q = '0;
    p = pos_q;
    if (p == 9'd0) begin
      name_ok = 1'b1;
      sig_ok = 1'b1;
      ent_hit = 1'b0;
      part_found = 1'b0;
    end
    if (p == OFS_BPS) bps_f[7:0] = b;
    if (p == OFS_BPS + 9'd1) bps_f[15:8] = b;
    if (p == OFS_SPC) spc_f = b;
    if (p == OFS_RSV) rsv_f[7:0] = b;
    if (p == OFS_RSV + 9'd1) rsv_f[15:8] = b;
    if (p == OFS_NFATS) nfats_f = b;
    if (p >= OFS_FATSZ && p < OFS_FATSZ + 9'd4) fatsz_f[8*(p - OFS_FATSZ) +: 8] = b;
    if (p >= OFS_ROOT && p < OFS_ROOT + 9'd4) root_f[8*(p - OFS_ROOT) +: 8] = b;
    if (p >= OFS_TYPE && p < OFS_TYPE + TYPE_LEN) begin
      if (b != FS_NAME[8*(4 - (p - OFS_TYPE)) +: 8]) name_ok = 1'b0;
    end
    if (p == SIG_OFS_A && b != SIG_BYTE_A) sig_ok = 1'b0;
    if (p == SIG_OFS_B && b != SIG_BYTE_B) sig_ok = 1'b0;
    // partition table scan, first fat32 entry wins
    if (p >= MBR_TABLE && p < MBR_END) begin
      off = p - MBR_TABLE;
      rel = off[3:0];
      if (rel == MBR_TYPE_OFS && !part_found && (b == PART_FAT32 || b == PART_FAT32_L))
        ent_hit = 1'b1;
      if (ent_hit && rel >= MBR_LBA_OFS && rel <= MBR_LBA_LAST) begin
        part_lba_f[8*(rel - MBR_LBA_OFS) +: 8] = b;
        if (rel == MBR_LBA_LAST) begin
          part_found = 1'b1;
          ent_hit = 1'b0;
        end
      end
    end
    pos_q = p + 9'd1;
    if (p == LAST_POS) begin
      r = '0;
      r.kind = KIND_NONE;
      if (sig_ok && bps_f == SECTOR_BYTES && spc_f != 8'd0 && nfats_f != 8'd0 &&
          fatsz_f != 32'd0 && root_f >= MIN_CLUSTER && name_ok) begin
        fat_start = base_lba + {16'd0, rsv_f};
        r.kind = KIND_BOOT;
        r.fat_lba = fat_start;
        r.data_start = fat_start + nfats_f * fatsz_f;
        r.clus_bytes = {spc_f, 9'd0};
        r.clus_secs = spc_f;
        r.root_clus = root_f;
      end else if (part_found) begin
        r.kind = KIND_MBR;
        r.part_lba = part_lba_f;
      end
      sector_q.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_cnt < 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    mismatch_cnt++;
  endtask

  // sender: one byte transfer per accepted cycle, random idle bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(byte_q[0].data, byte_q[0].start);
        byte_q.delete(0);
      end
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && !(s_axis_tvalid && !s_axis_tready) &&
                   $urandom_range(0, 9) == 0) begin
        tx_gap <= $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= byte_q[0].data;
        s_axis_tuser <= byte_q[0].start;
      end
    end
  end

  // receiver: check each result transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    sector_info_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sector_q.size() == 0) begin
          note_mismatch("result with none pending", 32'd0, {30'd0, m_axis_tuser});
        end else begin
          want = sector_q.pop_front();
          if (m_axis_tuser != want.kind)
            note_mismatch("sector_kind", {30'd0, want.kind}, {30'd0, m_axis_tuser});
          if (m_axis_tdata[31:0] != want.part_lba)
            note_mismatch("part_start", want.part_lba, m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] != want.fat_lba)
            note_mismatch("fat_lba", want.fat_lba, m_axis_tdata[63:32]);
          if (m_axis_tdata[95:64] != want.data_start)
            note_mismatch("data_start", want.data_start, m_axis_tdata[95:64]);
          if (m_axis_tdata[112:96] != want.clus_bytes)
            note_mismatch("cluster_bytes", {15'd0, want.clus_bytes},
                          {15'd0, m_axis_tdata[112:96]});
          if (m_axis_tdata[120:113] != want.clus_secs)
            note_mismatch("cluster_sectors", {24'd0, want.clus_secs},
                          {24'd0, m_axis_tdata[120:113]});
          if (m_axis_tdata[152:121] != want.root_clus)
            note_mismatch("root_dir_cluster", want.root_clus, m_axis_tdata[152:121]);
          if (m_axis_tdata[159:153] != 7'd0)
            note_mismatch("pad bits", 32'd0, {25'd0, m_axis_tdata[159:153]});
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so results back up into the block
  initial begin
    wait (stall_req == 1'b1);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic fill_sector(input logic noisy, input logic [7:0] bg);
    for (int i = 0; i < 512; i++) sec_buf[i] = noisy ? 8'($urandom) : bg;
  endtask

  task automatic put_sig();
    sec_buf[SIG_OFS_A] = SIG_BYTE_A;
    sec_buf[SIG_OFS_B] = SIG_BYTE_B;
  endtask

  task automatic put_entry(input int idx, input logic [7:0] ptype, input logic [31:0] lba);
    int base;
    base = MBR_TABLE + 16 * idx;
    sec_buf[base + MBR_TYPE_OFS] = ptype;
    for (int k = 0; k < 4; k++) sec_buf[base + MBR_LBA_OFS + k] = lba[8*k +: 8];
  endtask

  task automatic put_boot(input logic [7:0] spc, input logic [15:0] rsv,
                          input logic [7:0] nfats, input logic [31:0] fatsz,
                          input logic [31:0] root, input flaw_e flaw);
    logic [15:0] bps;
    logic [7:0]  t;
    int          k;
    bps = SECTOR_BYTES;
    t = 8'($urandom_range(1, 255));
    if (flaw == FLAW_BPS) bps = SECTOR_BYTES ^ (16'd1 << $urandom_range(0, 15));
    if (flaw == FLAW_SPC) spc = '0;
    if (flaw == FLAW_NFATS) nfats = '0;
    if (flaw == FLAW_FATSZ) fatsz = '0;
    if (flaw == FLAW_ROOT) root = $urandom_range(0, 1);
    sec_buf[OFS_BPS] = bps[7:0];
    sec_buf[OFS_BPS + 1] = bps[15:8];
    sec_buf[OFS_SPC] = spc;
    sec_buf[OFS_RSV] = rsv[7:0];
    sec_buf[OFS_RSV + 1] = rsv[15:8];
    sec_buf[OFS_NFATS] = nfats;
    for (k = 0; k < 4; k++) begin
      sec_buf[OFS_FATSZ + k] = fatsz[8*k +: 8];
      sec_buf[OFS_ROOT + k] = root[8*k +: 8];
    end
    for (k = 0; k < 5; k++) sec_buf[OFS_TYPE + k] = FS_NAME[8*(4 - k) +: 8];
    if (flaw == FLAW_TEXT) begin
      k = $urandom_range(0, 4);
      sec_buf[OFS_TYPE + k] = sec_buf[OFS_TYPE + k] ^ t;
    end
    put_sig();
    if (flaw == FLAW_SIG) begin
      if ($urandom_range(0, 1) == 0) sec_buf[SIG_OFS_A] = SIG_BYTE_A ^ t;
      else sec_buf[SIG_OFS_B] = SIG_BYTE_B ^ t;
    end
  endtask

  task automatic queue_bytes(input int n, input logic mark);
    sector_byte_t it;
    for (int i = 0; i < n; i++) begin
      it.data = sec_buf[i];
      it.start = (i == 0) && mark;
      byte_q.push_back(it);
    end
  endtask

  // random sector: mostly boot sectors and partition tables, some noise and cut-off sectors
  task automatic gen_sector();
    int          mode;
    logic        mark;
    flaw_e       flaw;
    logic [7:0]  ptype;
    logic [7:0]  spc;
    logic [7:0]  nfats;
    logic [31:0] fatsz;
    logic [31:0] root;
    fill_sector(1'($urandom_range(0, 1)), 8'h00);
    mode = $urandom_range(0, 9);
    if (mode <= 4 || mode == 8) begin
      flaw = FLAW_NONE;
      if ($urandom_range(0, 2) == 0) flaw = flaw_e'($urandom_range(FLAW_BPS, FLAW_SIG));
      spc = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 3) == 0) spc = ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd255;
      nfats = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 2)) : 8'($urandom_range(1, 255));
      fatsz = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 100000) : $urandom;
      root = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 9) : $urandom;
      put_boot(spc, 16'($urandom), nfats, fatsz, root, flaw);
    end
    if (mode >= 5 && mode <= 8) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0:       ptype = PART_FAT32;
          1:       ptype = PART_FAT32_L;
          default: ptype = 8'($urandom);
        endcase
        put_entry(k, ptype, $urandom);
      end
      if ($urandom_range(0, 3) != 0) put_sig();
    end
    mark = ($urandom_range(0, 3) != 0);
    // cut-off sector dropped by a start mark on the next one
    if ($urandom_range(0, 7) == 0) begin
      queue_bytes(($urandom_range(0, 1) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 511),
                  1'b1);
      mark = 1'b1;
    end
    queue_bytes(512, mark);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || sector_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_lba = v;
  endtask

  // stimulus phases
  initial begin
    int f;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed sectors, base at zero
    write_base(32'd0);
    fill_sector(1'b0, 8'h00);
    put_boot(8'd1, 16'd32, 8'd2, 32'd1000, 32'd2, FLAW_NONE);
    queue_bytes(512, 1'b1);
    fill_sector(1'b0, 8'hFF);
    put_boot(8'd255, 16'hFFFF, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FLAW_NONE);
    queue_bytes(512, 1'b1);
    // partition table without signature, no start mark
    fill_sector(1'b0, 8'h00);
    put_entry(0, 8'h83, 32'h0000_0800);
    put_entry(1, PART_FAT32_L, 32'h1234_5678);
    put_entry(2, PART_FAT32, 32'h9ABC_DEF0);
    queue_bytes(512, 1'b0);
    // boot sector and partition table in one sector
    fill_sector(1'b0, 8'h00);
    put_boot(8'd8, 16'd6, 8'd1, 32'd77, 32'd3, FLAW_NONE);
    put_entry(0, PART_FAT32, 32'h0000_0001);
    queue_bytes(512, 1'b1);
    // failed boot sector falls back to the last table entry
    fill_sector(1'b0, 8'h00);
    put_boot(8'd4, 16'd1, 8'd2, 32'd5, 32'd1, FLAW_ROOT);
    put_entry(3, PART_FAT32, 32'hFFFF_FFFF);
    queue_bytes(512, 1'b1);
    // each boot check failing alone
    for (f = FLAW_BPS; f <= FLAW_SIG; f++) begin
      fill_sector(1'b0, 8'h00);
      put_boot(8'd2, 16'd32, 8'd2, 32'd500, 32'd2, flaw_e'(f));
      queue_bytes(512, 1'b1);
    end
    // start mark mid-sector
    fill_sector(1'b1, 8'h00);
    queue_bytes(100, 1'b1);
    put_boot(8'd16, 16'd2, 8'd2, 32'd9, 32'd2, FLAW_NONE);
    queue_bytes(512, 1'b1);
    wait_idle();

    // top base, fat and data start wrap around
    write_base(32'hFFFF_FFFF);
    fill_sector(1'b0, 8'h00);
    put_boot(8'd128, 16'hFFFF, 8'd255, 32'hFFFF_FFFF, 32'd2, FLAW_NONE);
    queue_bytes(512, 1'b1);
    repeat (10) gen_sector();
    wait_idle();

    // receiver holds off while sectors keep coming
    write_base($urandom);
    stall_req = 1'b1;
    repeat (8) gen_sector();
    wait_idle();

    write_base(32'h8000_0000);
    repeat (12) gen_sector();
    wait_idle();

    // closing stretch without idle cycles
    write_base($urandom);
    quiet <= 1'b1;
    repeat (12) gen_sector();
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
